### design/lms_pkg.sv
package lms_pkg;

  // mission phases
  typedef enum logic [1:0] {
    PH_TAKEOFF = 2'd0,
    PH_PATROL  = 2'd1,
    PH_RETURN  = 2'd2,
    PH_LAND    = 2'd3
  } phase_t;

  // requests to the flight controller
  typedef enum logic [2:0] {
    REQ_NONE      = 3'd0,
    REQ_OFFBOARD  = 3'd1,
    REQ_AUTO_LAND = 3'd2,
    REQ_ARM       = 3'd3,
    REQ_COMPLETE  = 3'd4
  } req_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_WAYPOINT_A     = 3'd0,
    CFG_WAYPOINT_B     = 3'd1,
    CFG_WAYPOINT_C     = 3'd2,
    CFG_WAYPOINTS_USED = 3'd3,
    CFG_CRUISE_ALT     = 3'd4,
    CFG_TARGET_TMO     = 3'd5,
    CFG_VISION_TMO     = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] FC_MODE_OFFBOARD  = 2'd1;
  localparam logic [1:0] FC_MODE_AUTO_LAND = 2'd2;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // reset values of the configuration registers
  localparam logic [31:0] RST_WAYPOINT_A     = 32'd3000;
  localparam logic [31:0] RST_WAYPOINT_B     = 32'd196611000;
  localparam logic [31:0] RST_WAYPOINT_C     = 32'd196608000;
  localparam logic [1:0]  RST_WAYPOINTS_USED = 2'd3;
  localparam logic [14:0] RST_CRUISE_ALT     = 15'd2500;
  localparam logic [7:0]  RST_TARGET_TMO     = 8'd40;
  localparam logic [7:0]  RST_VISION_TMO     = 8'd10;

  // thresholds in mm, speeds in mm/s
  localparam logic signed [15:0] TAKEOFF_DONE_MM = 16'sd2300;
  localparam logic signed [15:0] GROUND_MM       = 16'sd300;
  localparam logic [16:0]        WP_REACH_MM     = 17'd300;
  localparam logic [18:0]        WP_REACH_SQ     = 19'd90000;
  localparam logic [16:0]        LAND_RADIUS_MM  = 17'd1000;
  localparam logic [20:0]        LAND_RADIUS_SQ  = 21'd1000000;
  localparam logic [8:0]         ZVEL_LIMIT      = 9'd300;
  localparam logic [8:0]         XY_LIMIT        = 9'd400;
  localparam logic signed [9:0]  DESCEND_VISION  = -10'sd400;
  localparam logic signed [9:0]  DESCEND_BLIND   = -10'sd300;
  localparam logic [7:0]         LAND_RETRY      = 8'd20;
  localparam logic [7:0]         MODE_RETRY      = 8'd100;
  localparam logic [7:0]         TIMER_MAX       = 8'd255;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] target_rel_x;
    logic signed [15:0] target_rel_y;
    logic [7:0]         target_age;
    logic signed [15:0] vision_vx;
    logic signed [15:0] vision_vy;
    logic [7:0]         vision_age;
    logic [1:0]         fc_mode;
    logic               fc_armed;
    logic [1:0]         service_ready;
  } in_item_t;

  typedef struct packed {
    logic signed [9:0] vel_x;
    logic signed [9:0] vel_y;
    logic signed [9:0] vel_z;
    phase_t            phase;
    req_t              request;
  } out_item_t;

  typedef struct packed {
    logic [31:0] waypoint_a;
    logic [31:0] waypoint_b;
    logic [31:0] waypoint_c;
    logic [1:0]  waypoints_used;
    logic [14:0] cruise_altitude;
    logic [7:0]  target_timeout;
    logic [7:0]  vision_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  wp_idx;
    logic [7:0]  timer;
  } state_t;

  // floor(v * 0.8) as floor(v * 205 / 256)
  function automatic logic signed [17:0] gain08(input logic signed [17:0] v);
    logic signed [25:0] p;
    p = {{8{v[17]}}, v};
    p = p * 26'sd205;
    return p[25:8];
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [9:0] clamp_vel(input logic signed [17:0] v,
                                                  input logic [8:0] lim);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    hi = {9'd0, lim};
    lo = -hi;
    if (v > hi) begin
      return hi[9:0];
    end else if (v < lo) begin
      return lo[9:0];
    end
    return v[9:0];
  endfunction

endpackage

### design/lms_cfg_regs.sv
module lms_cfg_regs
  import lms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waypoint_a      <= RST_WAYPOINT_A;
      cfg_r.waypoint_b      <= RST_WAYPOINT_B;
      cfg_r.waypoint_c      <= RST_WAYPOINT_C;
      cfg_r.waypoints_used  <= RST_WAYPOINTS_USED;
      cfg_r.cruise_altitude <= RST_CRUISE_ALT;
      cfg_r.target_timeout  <= RST_TARGET_TMO;
      cfg_r.vision_timeout  <= RST_VISION_TMO;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WAYPOINT_A:     cfg_r.waypoint_a      <= cfg_wdata;
        CFG_WAYPOINT_B:     cfg_r.waypoint_b      <= cfg_wdata;
        CFG_WAYPOINT_C:     cfg_r.waypoint_c      <= cfg_wdata;
        CFG_WAYPOINTS_USED: cfg_r.waypoints_used  <= cfg_wdata[1:0];
        CFG_CRUISE_ALT:     cfg_r.cruise_altitude <= cfg_wdata[14:0];
        CFG_TARGET_TMO:     cfg_r.target_timeout  <= cfg_wdata[7:0];
        CFG_VISION_TMO:     cfg_r.vision_timeout  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/lms_guidance.sv
module lms_guidance
  import lms_pkg::*;
(
  input  in_item_t          item,
  input  cfg_t              cfg,
  input  phase_t            phase,
  input  logic [1:0]        wp_idx,
  output logic signed [9:0] vel_x,
  output logic signed [9:0] vel_y,
  output logic signed [9:0] vel_z,
  output phase_t            phase_nxt,
  output logic [1:0]        wp_idx_nxt
);

  logic signed [17:0] alt_err;
  logic signed [9:0]  zhold;
  logic [31:0]        wp;
  logic signed [15:0] wp_x;
  logic signed [15:0] wp_y;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic [18:0]        wp_dsq;
  logic               wp_reached;
  logic [16:0]        atx;
  logic [16:0]        aty;
  logic [20:0]        tgt_dsq;
  logic               tgt_close;
  logic               tgt_fresh;
  logic               vis_fresh;
  logic [1:0]         idx_inc;

  assign alt_err = $signed({3'd0, cfg.cruise_altitude}) - $signed({{2{item.pos_z[15]}}, item.pos_z});
  assign zhold   = clamp_vel(gain08(alt_err), ZVEL_LIMIT);

  // waypoint index three falls back to the third waypoint
  always_comb begin
    case (wp_idx)
      2'd0:    wp = cfg.waypoint_a;
      2'd1:    wp = cfg.waypoint_b;
      default: wp = cfg.waypoint_c;
    endcase
  end

  assign wp_x = wp[15:0];
  assign wp_y = wp[31:16];
  assign dx   = {wp_x[15], wp_x} - {item.pos_x[15], item.pos_x};
  assign dy   = {wp_y[15], wp_y} - {item.pos_y[15], item.pos_y};
  assign adx  = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady  = dy[16] ? 17'(-dy) : 17'(dy);

  // only small offsets can be inside the radius, so the squares stay narrow
  assign wp_dsq     = 19'(adx[8:0] * adx[8:0]) + 19'(ady[8:0] * ady[8:0]);
  assign wp_reached = (adx < WP_REACH_MM) && (ady < WP_REACH_MM) && (wp_dsq < WP_REACH_SQ);

  assign atx = item.target_rel_x[15] ? 17'(-{1'b1, item.target_rel_x})
                                     : {1'b0, item.target_rel_x};
  assign aty = item.target_rel_y[15] ? 17'(-{1'b1, item.target_rel_y})
                                     : {1'b0, item.target_rel_y};
  assign tgt_dsq   = 21'(atx[9:0] * atx[9:0]) + 21'(aty[9:0] * aty[9:0]);
  assign tgt_close = (atx < LAND_RADIUS_MM) && (aty < LAND_RADIUS_MM) &&
                     (tgt_dsq < LAND_RADIUS_SQ);

  assign tgt_fresh = item.target_age < cfg.target_timeout;
  assign vis_fresh = item.vision_age < cfg.vision_timeout;
  assign idx_inc   = wp_idx + 2'd1;

  always_comb begin
    vel_x      = '0;
    vel_y      = '0;
    vel_z      = zhold;
    phase_nxt  = phase;
    wp_idx_nxt = wp_idx;
    case (phase)
      PH_TAKEOFF: begin
        if (item.pos_z > TAKEOFF_DONE_MM) begin
          phase_nxt = PH_PATROL;
        end
      end
      PH_PATROL: begin
        if (wp_reached) begin
          wp_idx_nxt = idx_inc;
          if (idx_inc >= cfg.waypoints_used) begin
            phase_nxt = PH_RETURN;
          end
        end else begin
          vel_x = clamp_vel(18'($signed({{1{dx[16]}}, dx}) >>> 1), XY_LIMIT);
          vel_y = clamp_vel(18'($signed({{1{dy[16]}}, dy}) >>> 1), XY_LIMIT);
        end
      end
      default: begin
        if (tgt_fresh) begin
          vel_x = clamp_vel(gain08({{2{item.target_rel_x[15]}}, item.target_rel_x}), XY_LIMIT);
          vel_y = clamp_vel(gain08({{2{item.target_rel_y[15]}}, item.target_rel_y}), XY_LIMIT);
          if (tgt_close) begin
            phase_nxt = PH_LAND;
            if (vis_fresh) begin
              vel_x = clamp_vel({{2{item.vision_vx[15]}}, item.vision_vx}, XY_LIMIT);
              vel_y = clamp_vel({{2{item.vision_vy[15]}}, item.vision_vy}, XY_LIMIT);
              vel_z = DESCEND_VISION;
            end else begin
              vel_z = DESCEND_BLIND;
            end
          end else begin
            phase_nxt = PH_RETURN;
          end
        end
      end
    endcase
  end

endmodule

### design/lms_request.sv
module lms_request
  import lms_pkg::*;
(
  input  phase_t             phase_nxt,
  input  logic signed [15:0] pos_z,
  input  logic [1:0]         fc_mode,
  input  logic               fc_armed,
  input  logic [1:0]         service_ready,
  input  logic [7:0]         timer,
  output req_t               request,
  output logic [7:0]         timer_nxt
);

  logic [7:0] timer_inc;
  logic       near_ground;

  assign timer_inc   = (timer == TIMER_MAX) ? TIMER_MAX : timer + 8'd1;
  assign near_ground = (phase_nxt == PH_LAND) && (pos_z < GROUND_MM);

  always_comb begin
    request   = REQ_NONE;
    timer_nxt = timer_inc;
    if (near_ground) begin
      if ((fc_mode != FC_MODE_AUTO_LAND) && (timer_inc > LAND_RETRY)) begin
        if (service_ready[0]) request = REQ_AUTO_LAND;
        timer_nxt = '0;
      end
    end else if ((fc_mode != FC_MODE_OFFBOARD) && (timer_inc > MODE_RETRY)) begin
      if (service_ready[0]) request = REQ_OFFBOARD;
      timer_nxt = '0;
    end else if (!fc_armed && (timer_inc > MODE_RETRY)) begin
      if ((phase_nxt == PH_RETURN) || (phase_nxt == PH_LAND)) begin
        // timer left running so completion repeats
        request = REQ_COMPLETE;
      end else begin
        if (service_ready[1]) request = REQ_ARM;
        timer_nxt = '0;
      end
    end
  end

endmodule

### design/landing_mission_sequencer.sv
// landing mission sequencer: one transaction per 50 ms control tick. each tick
// carries position, platform offset and vision command plus flight controller
// status; the block answers with one transaction holding a velocity setpoint,
// the mission phase after the tick and a mode, arm or completion request.
// throughput is one tick per clock cycle while the output is not stalled; a
// result passes the input register, then the single pass of guidance and
// request logic into the output register, which holds it while the output
// is stalled.
// the mission state is updated as each tick leaves the input register, so the
// next tick always sees it. configuration is written through cfg_we/cfg_index
// and should only change while no tick is in flight.
module landing_mission_sequencer
  import lms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input tick stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], target_rel_x[63:48],
  // target_rel_y[79:64], target_age[87:80], vision_vx[103:88],
  // vision_vy[119:104], vision_age[127:120], fc_mode[129:128],
  // fc_armed[130], service_ready[132:131], zero pad[135:133]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vel_x[9:0], vel_y[19:10], vel_z[29:20], phase[31:30],
  // request[34:32], zero pad[39:35]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t       cfg;
  in_item_t   in_item;
  in_item_t   stage_r;
  logic       stage_vld_r;
  logic       advance;
  state_t     st_r;
  state_t     st_nxt;
  out_item_t  result;
  out_item_t  out_r;
  logic       out_vld_r;

  // unpack the incoming transaction, lowest field first
  assign in_item.pos_x         = in_tdata[15:0];
  assign in_item.pos_y         = in_tdata[31:16];
  assign in_item.pos_z         = in_tdata[47:32];
  assign in_item.target_rel_x  = in_tdata[63:48];
  assign in_item.target_rel_y  = in_tdata[79:64];
  assign in_item.target_age    = in_tdata[87:80];
  assign in_item.vision_vx     = in_tdata[103:88];
  assign in_item.vision_vy     = in_tdata[119:104];
  assign in_item.vision_age    = in_tdata[127:120];
  assign in_item.fc_mode       = in_tdata[129:128];
  assign in_item.fc_armed      = in_tdata[130];
  assign in_item.service_ready = in_tdata[132:131];

  // tick moves on when the output register is free or being drained
  assign advance   = stage_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stage_vld_r || advance;

  lms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_tready) begin
      stage_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_r <= in_item;
    end
  end

  // phase, waypoint and velocity decisions
  lms_guidance u_guid (
    .item       (stage_r),
    .cfg        (cfg),
    .phase      (st_r.phase),
    .wp_idx     (st_r.wp_idx),
    .vel_x      (result.vel_x),
    .vel_y      (result.vel_y),
    .vel_z      (result.vel_z),
    .phase_nxt  (st_nxt.phase),
    .wp_idx_nxt (st_nxt.wp_idx)
  );

  // request arbitration works on the phase after this tick
  lms_request u_req (
    .phase_nxt     (st_nxt.phase),
    .pos_z         (stage_r.pos_z),
    .fc_mode       (stage_r.fc_mode),
    .fc_armed      (stage_r.fc_armed),
    .service_ready (stage_r.service_ready),
    .timer         (st_r.timer),
    .request       (result.request),
    .timer_nxt     (st_nxt.timer)
  );

  assign result.phase = st_nxt.phase;

  // mission state commits once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= PH_TAKEOFF;
      st_r.wp_idx <= '0;
      st_r.timer  <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_r.request, out_r.phase, out_r.vel_z, out_r.vel_y,
                       out_r.vel_x};

endmodule
